// File: rtl/dagp_pkg.sv
// Shared types and constants of the graph address text parser.
package dagp_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CHOSEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_TYPE = 1'd1;

    // Limits
    localparam int MAX_ROWS    = 9;
    localparam int MAX_LEN     = 1024;
    localparam int CONS_W      = $clog2(MAX_LEN + 1);
    localparam int QUEUE_DEPTH = 4;

    // Row layout
    localparam int XID_DIGITS = 8;
    localparam int XID_WORDS  = 5;
    localparam int MAX_EDGES  = 4;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_GT    = 8'h3e;

    // Edge encoding
    localparam logic [7:0]  EDGE_EMPTY  = 8'h7f;
    localparam logic [7:0]  EDGE_CHOSEN = 8'h80;
    localparam logic [31:0] EDGES_EMPTY = 32'h7f7f7f7f;

    // Result kinds
    localparam logic [1:0] KIND_TYPE   = 2'd0;
    localparam logic [1:0] KIND_XID    = 2'd1;
    localparam logic [1:0] KIND_EDGES  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Final status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_ROWS   = 2'd2;

    // One result item
    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        row_index;
        logic [2:0]        word_index;
        logic [31:0]       value;
        logic [1:0]        status;
        logic [CONS_W-1:0] consumed;
        logic              invalid_mark;
        logic              done_res;
    } res_t;

    // Up to two results written into the queue in one cycle
    typedef struct packed {
        logic v0;
        res_t r0;
        logic v1;
        res_t r1;
    } push_t;

endpackage

// File: rtl/dagp_front.sv
// Front end: configuration registers, character classification and parse state machine.
module dagp_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [7:0]                           ch,
    input  logic                                 last,
    input  logic                                 cfg_we,
    input  logic [dagp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dagp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output dagp_pkg::push_t                      push
);

    typedef enum logic [2:0] {
        PH_START, PH_TYPE, PH_XID, PH_EDASH, PH_EDGE, PH_SEP, PH_NL, PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        RC_NONE, RC_END, RC_SYNTAX, RC_ROWS
    } rcode_t;

    localparam int CW = dagp_pkg::CONS_W;

    phase_t         phase_reg, phase_next;
    logic [31:0]    acc_reg, acc_next;
    logic [3:0]     dc_reg, dc_next;
    logic [3:0]     rc_reg, rc_next;
    logic [2:0]     wc_reg, wc_next;
    logic [2:0]     ec_reg, ec_next;
    logic [31:0]    eb_reg, eb_next;
    logic           cp_reg, cp_next;
    logic [CW-1:0]  cc_reg, cc_next;
    logic           inv_reg, inv_next;
    logic           ign_chosen_reg;
    logic [31:0]    rsv_type_reg;

    logic           hex_ok;
    logic [3:0]     hex_v;
    logic           b36_ok;
    logic [5:0]     b36_v;

    function automatic dagp_pkg::res_t mk_field(
        input logic [1:0]  kind,
        input logic [3:0]  row,
        input logic [2:0]  word,
        input logic [31:0] value
    );
        dagp_pkg::res_t r;
        r            = '0;
        r.kind       = kind;
        r.row_index  = row;
        r.word_index = word;
        r.value      = value;
        return r;
    endfunction

    // Classify the character as hex and base-36 digit
    always_comb
    begin
        hex_ok = 1'b1;
        hex_v  = '0;
        b36_ok = 1'b1;
        b36_v  = '0;
        if (ch inside {[8'h30:8'h39]})
        begin
            hex_v = 4'(ch - 8'h30);
            b36_v = 6'(ch - 8'h30);
        end
        else if (ch inside {[8'h61:8'h7a]})
        begin
            hex_ok = (ch inside {[8'h61:8'h66]});
            hex_v  = 4'(ch - 8'h57);
            b36_v  = 6'(ch - 8'h57);
        end
        else if (ch inside {[8'h41:8'h5a]})
        begin
            hex_ok = (ch inside {[8'h41:8'h46]});
            hex_v  = 4'(ch - 8'h37);
            b36_v  = 6'(ch - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
            b36_ok = 1'b0;
        end
    end

    // Parse one item: the character, then the end of text when marked last
    always_comb
    begin
        rcode_t         r;
        logic           stop;
        logic           go_sep;
        logic           do_clear;
        logic           a_v;
        logic           b_v;
        dagp_pkg::res_t a_rec;
        dagp_pkg::res_t b_rec;
        dagp_pkg::res_t st_rec;
        logic [1:0]     lane;
        logic [7:0]     ebyte;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        dc_next    = dc_reg;
        rc_next    = rc_reg;
        wc_next    = wc_reg;
        ec_next    = ec_reg;
        eb_next    = eb_reg;
        cp_next    = cp_reg;
        cc_next    = cc_reg;
        inv_next   = inv_reg;
        r          = RC_NONE;
        stop       = 1'b0;
        go_sep     = 1'b0;
        do_clear   = 1'b0;
        a_v        = 1'b0;
        b_v        = 1'b0;
        a_rec      = '0;
        b_rec      = '0;
        st_rec     = '0;
        lane       = '0;
        ebyte      = '0;
        push       = '0;

        if (in_valid && !in_stall)
        begin
            if (phase_reg == PH_DRAIN)
            begin
                // Drop characters up to the one marked last
                do_clear = last;
            end
            else
            begin
                // Start of text and start of row both open a type field
                if (phase_reg == PH_START || phase_reg == PH_NL)
                begin
                    if (phase_reg == PH_START && ch == dagp_pkg::CH_BANG)
                    begin
                        inv_next = 1'b1;
                        stop     = 1'b1;
                    end
                    if (phase_reg == PH_NL && ch == dagp_pkg::CH_NL)
                        stop = 1'b1;
                    phase_next = PH_TYPE;
                    acc_next   = '0;
                    dc_next    = '0;
                end

                if (!stop)
                begin
                    case (phase_next)
                        PH_TYPE:
                        begin
                            if (hex_ok && dc_next < 4'(dagp_pkg::XID_DIGITS))
                            begin
                                acc_next = {acc_next[27:0], hex_v};
                                dc_next  = dc_next + 4'd1;
                            end
                            else if (ch == dagp_pkg::CH_DASH && dc_next != 4'd0 &&
                                     acc_next != rsv_type_reg)
                            begin
                                a_v        = 1'b1;
                                a_rec      = mk_field(dagp_pkg::KIND_TYPE, rc_next, 3'd0,
                                                      acc_next);
                                acc_next   = '0;
                                dc_next    = '0;
                                wc_next    = '0;
                                phase_next = PH_XID;
                            end
                            else
                            begin
                                r = RC_SYNTAX;
                            end
                        end
                        PH_XID:
                        begin
                            if (!hex_ok)
                            begin
                                r = RC_SYNTAX;
                            end
                            else
                            begin
                                acc_next = {acc_next[27:0], hex_v};
                                dc_next  = dc_next + 4'd1;
                                if (dc_next == 4'(dagp_pkg::XID_DIGITS))
                                begin
                                    a_v      = 1'b1;
                                    a_rec    = mk_field(dagp_pkg::KIND_XID, rc_next, wc_next,
                                                        acc_next);
                                    acc_next = '0;
                                    dc_next  = '0;
                                    wc_next  = wc_next + 3'd1;
                                    if (wc_next == 3'(dagp_pkg::XID_WORDS))
                                        phase_next = PH_EDASH;
                                end
                            end
                        end
                        PH_EDASH:
                        begin
                            eb_next = dagp_pkg::EDGES_EMPTY;
                            ec_next = '0;
                            cp_next = 1'b0;
                            if (ch == dagp_pkg::CH_DASH)
                            begin
                                phase_next = PH_EDGE;
                            end
                            else
                            begin
                                a_v        = 1'b1;
                                a_rec      = mk_field(dagp_pkg::KIND_EDGES, rc_next, 3'd0,
                                                      eb_next);
                                phase_next = PH_SEP;
                                go_sep     = 1'b1;
                            end
                        end
                        PH_EDGE:
                        begin
                            if (ch == dagp_pkg::CH_GT && !cp_next)
                            begin
                                cp_next = 1'b1;
                            end
                            else if (b36_ok || ch == dagp_pkg::CH_STAR)
                            begin
                                ebyte = b36_ok ? {2'b00, b36_v} : dagp_pkg::EDGE_EMPTY;
                                if (cp_next && !ign_chosen_reg)
                                    ebyte = ebyte | dagp_pkg::EDGE_CHOSEN;
                                lane = 2'd3 - ec_next[1:0];
                                eb_next[{lane, 3'b000} +: 8] = ebyte;
                                ec_next = ec_next + 3'd1;
                                cp_next = 1'b0;
                                if (ec_next == 3'(dagp_pkg::MAX_EDGES))
                                begin
                                    a_v        = 1'b1;
                                    a_rec      = mk_field(dagp_pkg::KIND_EDGES, rc_next, 3'd0,
                                                          eb_next);
                                    phase_next = PH_SEP;
                                end
                            end
                            else if (ec_next == 3'd0)
                            begin
                                r = RC_SYNTAX;
                            end
                            else
                            begin
                                a_v        = 1'b1;
                                a_rec      = mk_field(dagp_pkg::KIND_EDGES, rc_next, 3'd0,
                                                      eb_next);
                                phase_next = PH_SEP;
                                go_sep     = 1'b1;
                            end
                        end
                        PH_SEP:
                        begin
                            go_sep = 1'b1;
                        end
                        default:
                        begin
                            r = RC_NONE;
                        end
                    endcase

                    // Row separator or end of address
                    if (go_sep)
                    begin
                        if (ch == dagp_pkg::CH_COLON)
                        begin
                            if (({1'b0, rc_next} + 5'd1) >= 5'(dagp_pkg::MAX_ROWS))
                            begin
                                r = RC_ROWS;
                            end
                            else
                            begin
                                rc_next    = rc_next + 4'd1;
                                phase_next = PH_NL;
                            end
                        end
                        else if (ch == dagp_pkg::CH_NUL)
                        begin
                            r = RC_END;
                        end
                        else
                        begin
                            r = RC_SYNTAX;
                        end
                    end
                end

                // Count the character and apply the end of text
                if (r == RC_NONE)
                begin
                    if (cc_reg < CW'(dagp_pkg::MAX_LEN))
                        cc_next = cc_reg + CW'(1);
                    if (last)
                    begin
                        case (phase_next)
                            PH_EDASH:
                            begin
                                b_v   = 1'b1;
                                b_rec = mk_field(dagp_pkg::KIND_EDGES, rc_next, 3'd0,
                                                 dagp_pkg::EDGES_EMPTY);
                                r     = RC_END;
                            end
                            PH_EDGE:
                            begin
                                if (ec_next == 3'd0)
                                begin
                                    r = RC_SYNTAX;
                                end
                                else
                                begin
                                    b_v   = 1'b1;
                                    b_rec = mk_field(dagp_pkg::KIND_EDGES, rc_next, 3'd0,
                                                     eb_next);
                                    r     = RC_END;
                                end
                            end
                            PH_SEP:
                            begin
                                r = RC_END;
                            end
                            default:
                            begin
                                r = RC_SYNTAX;
                            end
                        endcase
                    end
                end

                // Collect field results in order
                a_rec.invalid_mark = inv_next;
                b_rec.invalid_mark = inv_next;
                push.v0 = a_v | b_v;
                push.r0 = a_v ? a_rec : b_rec;
                push.v1 = a_v & b_v;
                push.r1 = b_rec;

                // Add the final status, or fold it into a crowded second result
                if (r != RC_NONE)
                begin
                    st_rec.kind         = dagp_pkg::KIND_STATUS;
                    st_rec.invalid_mark = inv_next;
                    st_rec.done_res     = 1'b1;
                    st_rec.consumed     = cc_next;
                    case (r)
                        RC_END:    st_rec.status = dagp_pkg::ST_OK;
                        RC_SYNTAX: st_rec.status = dagp_pkg::ST_SYNTAX;
                        RC_ROWS:   st_rec.status = dagp_pkg::ST_ROWS;
                        default:   st_rec.status = dagp_pkg::ST_OK;
                    endcase
                    if (push.v1)
                    begin
                        push.r1.status   = st_rec.status;
                        push.r1.consumed = cc_next;
                        push.r1.done_res = 1'b1;
                    end
                    else if (push.v0)
                    begin
                        push.v1 = 1'b1;
                        push.r1 = st_rec;
                    end
                    else
                    begin
                        push.v0 = 1'b1;
                        push.r0 = st_rec;
                    end
                    if (last)
                        do_clear = 1'b1;
                    else
                        phase_next = PH_DRAIN;
                end
            end

            // Start afresh after the text
            if (do_clear)
            begin
                phase_next = PH_START;
                acc_next   = '0;
                dc_next    = '0;
                rc_next    = '0;
                wc_next    = '0;
                ec_next    = '0;
                eb_next    = dagp_pkg::EDGES_EMPTY;
                cp_next    = 1'b0;
                cc_next    = '0;
                inv_next   = 1'b0;
            end
        end
    end

    // Hold parse state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            acc_reg        <= '0;
            dc_reg         <= '0;
            rc_reg         <= '0;
            wc_reg         <= '0;
            ec_reg         <= '0;
            eb_reg         <= dagp_pkg::EDGES_EMPTY;
            cp_reg         <= 1'b0;
            cc_reg         <= '0;
            inv_reg        <= 1'b0;
            ign_chosen_reg <= 1'b0;
            rsv_type_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            dc_reg    <= dc_next;
            rc_reg    <= rc_next;
            wc_reg    <= wc_next;
            ec_reg    <= ec_next;
            eb_reg    <= eb_next;
            cp_reg    <= cp_next;
            cc_reg    <= cc_next;
            inv_reg   <= inv_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dagp_pkg::REG_IGNORE_CHOSEN: ign_chosen_reg <= cfg_data[0];
                    dagp_pkg::REG_RESERVED_TYPE: rsv_type_reg   <= cfg_data[31:0];
                    default:                     rsv_type_reg   <= rsv_type_reg;
                endcase
            end
        end
    end

endmodule

// File: rtl/dagp_back.sv
// Back end: result queue taking up to two items a cycle and presenting one at the output.
module dagp_back
#(
    parameter int DEPTH = dagp_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  dagp_pkg::push_t push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_stall,
    output dagp_pkg::res_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dagp_pkg::res_t    queue_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_one;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Accept new items only with room for two results
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = queue_reg[rd_ptr_reg];
    assign wr_ptr_one = ptr_inc(wr_ptr_reg);

    // Advance pointers and fill level
    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        if (push.v1)
            wr_ptr_next = ptr_inc(wr_ptr_one);
        else if (push.v0)
            wr_ptr_next = wr_ptr_one;
        else
            wr_ptr_next = wr_ptr_reg;
        count_next = count_reg + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
    end

    // Store results
    always_ff @(posedge clk)
    begin
        if (push.v0)
            queue_reg[wr_ptr_reg] <= push.r0;
        if (push.v1)
            queue_reg[wr_ptr_one] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/dag_address_text_parser_core.sv
// Graph address text parser: one character per cycle, results through a small queue.
// Each result is written into the result queue when its character is accepted and is offered from its head.
// Throughput: one character per cycle; the single output port drains one result per
//   cycle while out_stall is low, so a character that yields two results takes two output
//   slots, and the input stalls while the result queue has fewer than two free entries.
// Reset: parse state returns to start of text, ignore_chosen and reserved_type read 0.
module dag_address_text_parser_core
#(
    parameter int QUEUE_DEPTH = dagp_pkg::QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        ch,
    input  logic                              last,
    input  logic                              cfg_we,
    input  logic [dagp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dagp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        kind,
    output logic [3:0]                        row_index,
    output logic [2:0]                        word_index,
    output logic [31:0]                       value,
    output logic [1:0]                        status,
    output logic [dagp_pkg::CONS_W-1:0]       consumed,
    output logic                              invalid_mark,
    output logic                              done_res
);

    dagp_pkg::push_t push;
    dagp_pkg::res_t  head;
    logic            room;

    assign in_stall = !room;

    dagp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    dagp_back #(.DEPTH(QUEUE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // Spread the head item onto the result ports
    assign kind         = head.kind;
    assign row_index    = head.row_index;
    assign word_index   = head.word_index;
    assign value        = head.value;
    assign status       = head.status;
    assign consumed     = head.consumed;
    assign invalid_mark = head.invalid_mark;
    assign done_res     = head.done_res;

endmodule

// File: verif/dag_address_text_parser_core_tb.sv
// Self-checking testbench for the graph address text parser core.
`timescale 1ns / 100ps

module dag_address_text_parser_core_tb;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int END_OF_TEXT    = 256;
    localparam int TYPE_DIGITS    = 8;
    localparam int PHASE_ITEMS    = 260;
    localparam int MAX_MSG_LINES  = 30;

    typedef enum int {
        P_START, P_TYPE, P_XID, P_EDASH, P_EDGE, P_SEP, P_NL, P_DRAIN
    } parse_phase_t;
    typedef enum int {STEP_MORE, STEP_END_OK, STEP_SYNTAX, STEP_ROWS} parse_code_t;

    // DUT connections, all inputs known from time zero
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [7:0]                      ch = 8'h00;
    logic                            last = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [dagp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dagp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      kind;
    logic [3:0]                      row_index;
    logic [2:0]                      word_index;
    logic [31:0]                     value;
    logic [1:0]                      status;
    logic [dagp_pkg::CONS_W-1:0]     consumed;
    logic                            invalid_mark;
    logic                            done_res;

    // Parser model state and register copies
    parse_phase_t ps_phase = P_START;
    int           ps_digits = 0;
    logic [31:0]  ps_acc = '0;
    int           ps_row = 0;
    int           ps_word = 0;
    int           ps_edge_n = 0;
    logic [31:0]  ps_edges = dagp_pkg::EDGES_EMPTY;
    bit           ps_gt_pending = 1'b0;
    int           ps_chars = 0;
    bit           ps_bang = 1'b0;
    bit           cfg_ignore_chosen = 1'b0;
    logic [31:0]  cfg_reserved_type = '0;

    // Fields produced by one character, and fields still owed by the block
    dagp_pkg::res_t step_res [2];
    int             step_n;
    dagp_pkg::res_t expected_fields [$];

    // Text under construction
    logic [7:0]   txt [$];

    bit           send_gaps = 1'b1;
    bit           recv_stalls = 1'b1;
    int           stall_left = 0;
    int           cycle_count = 0;
    int           errors = 0;
    int           chars_sent = 0;
    int           texts_sent = 0;
    int           results_seen = 0;

    dag_address_text_parser_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .row_index    (row_index),
        .word_index   (word_index),
        .value        (value),
        .status       (status),
        .consumed     (consumed),
        .invalid_mark (invalid_mark),
        .done_res     (done_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d fields outstanding",
                     cycle_count, expected_fields.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stall the result side in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (!recv_stalls)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_MSG_LINES)
            $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("field %0d %s: got %0h, want %0h",
                                      results_seen, name, got, want));
    endtask

    // Compare each accepted field with the oldest one owed
    always @(posedge clk)
    begin : check_results
        dagp_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_fields.size() == 0)
            begin
                report_mismatch($sformatf("unexpected field kind %0d value %0h", kind, value));
            end
            else
            begin
                want = expected_fields.pop_front();
                check_field("kind", 32'(kind), 32'(want.kind));
                check_field("row_index", 32'(row_index), 32'(want.row_index));
                check_field("word_index", 32'(word_index), 32'(want.word_index));
                check_field("value", value, want.value);
                check_field("status", 32'(status), 32'(want.status));
                check_field("consumed", 32'(consumed), 32'(want.consumed));
                check_field("invalid_mark", 32'(invalid_mark), 32'(want.invalid_mark));
                check_field("done_res", 32'(done_res), 32'(want.done_res));
            end
            results_seen++;
        end
    end

    function automatic int hex_value(int c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic int b36_value(int c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "z") return c - "a" + 10;
        if (c >= "A" && c <= "Z") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void clear_parse();
        ps_phase = P_START;
        ps_digits = 0;
        ps_acc = '0;
        ps_row = 0;
        ps_word = 0;
        ps_edge_n = 0;
        ps_edges = dagp_pkg::EDGES_EMPTY;
        ps_gt_pending = 1'b0;
        ps_chars = 0;
        ps_bang = 1'b0;
    endfunction

    // Record one field of the current row; at most two per character
    function automatic void push_field(logic [1:0] k, logic [31:0] v, logic [2:0] w);
        dagp_pkg::res_t r;
        if (step_n >= 2) return;
        r = '0;
        r.kind = k;
        r.row_index = ps_row[3:0];
        r.word_index = w;
        r.value = v;
        r.invalid_mark = ps_bang;
        step_res[step_n] = r;
        step_n++;
    endfunction

    // Advance the row parser by one character (or the end of text)
    function automatic parse_code_t parse_char(int c);
        int         v;
        logic [7:0] b;
        while (1'b1)
        begin
            case (ps_phase)
                P_START:
                begin
                    ps_phase = P_TYPE;
                    ps_acc = '0;
                    ps_digits = 0;
                    if (c == dagp_pkg::CH_BANG)
                    begin
                        ps_bang = 1'b1;
                        return STEP_MORE;
                    end
                end
                P_TYPE:
                begin
                    v = hex_value(c);
                    if (v >= 0 && ps_digits < TYPE_DIGITS)
                    begin
                        ps_acc = (ps_acc << 4) | v;
                        ps_digits++;
                        return STEP_MORE;
                    end
                    if (c == dagp_pkg::CH_DASH && ps_digits > 0 &&
                        ps_acc != cfg_reserved_type)
                    begin
                        push_field(dagp_pkg::KIND_TYPE, ps_acc, '0);
                        ps_acc = '0;
                        ps_digits = 0;
                        ps_word = 0;
                        ps_phase = P_XID;
                        return STEP_MORE;
                    end
                    return STEP_SYNTAX;
                end
                P_XID:
                begin
                    v = hex_value(c);
                    if (v < 0) return STEP_SYNTAX;
                    ps_acc = (ps_acc << 4) | v;
                    ps_digits++;
                    if (ps_digits >= dagp_pkg::XID_DIGITS)
                    begin
                        push_field(dagp_pkg::KIND_XID, ps_acc, ps_word[2:0]);
                        ps_acc = '0;
                        ps_digits = 0;
                        ps_word++;
                        if (ps_word >= dagp_pkg::XID_WORDS) ps_phase = P_EDASH;
                    end
                    return STEP_MORE;
                end
                P_EDASH:
                begin
                    ps_edges = dagp_pkg::EDGES_EMPTY;
                    ps_edge_n = 0;
                    ps_gt_pending = 1'b0;
                    if (c == dagp_pkg::CH_DASH)
                    begin
                        ps_phase = P_EDGE;
                        return STEP_MORE;
                    end
                    push_field(dagp_pkg::KIND_EDGES, ps_edges, '0);
                    ps_phase = P_SEP;
                end
                P_EDGE:
                begin
                    if (c == dagp_pkg::CH_GT && !ps_gt_pending)
                    begin
                        ps_gt_pending = 1'b1;
                        return STEP_MORE;
                    end
                    v = b36_value(c);
                    if (v >= 0 || c == dagp_pkg::CH_STAR)
                    begin
                        b = (v >= 0) ? v[7:0] : dagp_pkg::EDGE_EMPTY;
                        if (ps_gt_pending && !cfg_ignore_chosen)
                            b = b | dagp_pkg::EDGE_CHOSEN;
                        ps_edges[8 * (3 - ps_edge_n) +: 8] = b;
                        ps_edge_n++;
                        ps_gt_pending = 1'b0;
                        if (ps_edge_n >= dagp_pkg::MAX_EDGES)
                        begin
                            push_field(dagp_pkg::KIND_EDGES, ps_edges, '0);
                            ps_phase = P_SEP;
                        end
                        return STEP_MORE;
                    end
                    if (ps_edge_n == 0) return STEP_SYNTAX;
                    push_field(dagp_pkg::KIND_EDGES, ps_edges, '0);
                    ps_phase = P_SEP;
                end
                P_SEP:
                begin
                    if (c == dagp_pkg::CH_COLON)
                    begin
                        if (ps_row + 1 >= dagp_pkg::MAX_ROWS) return STEP_ROWS;
                        ps_row++;
                        ps_phase = P_NL;
                        return STEP_MORE;
                    end
                    if (c == dagp_pkg::CH_NUL || c == END_OF_TEXT) return STEP_END_OK;
                    return STEP_SYNTAX;
                end
                P_NL:
                begin
                    ps_phase = P_TYPE;
                    ps_acc = '0;
                    ps_digits = 0;
                    if (c == dagp_pkg::CH_NL) return STEP_MORE;
                end
                default:
                    return STEP_MORE;
            endcase
        end
        return STEP_MORE;
    endfunction

    // Work out the fields one accepted character owes and queue them
    function automatic void parse_step(logic [7:0] c, logic is_last);
        parse_code_t r;
        logic [1:0]  st;
        step_n = 0;
        if (ps_phase == P_DRAIN)
        begin
            if (is_last) clear_parse();
            return;
        end
        r = parse_char(int'(c));
        if (r == STEP_MORE)
        begin
            if (ps_chars < dagp_pkg::MAX_LEN) ps_chars++;
            if (is_last)
            begin
                r = parse_char(END_OF_TEXT);
                if (r == STEP_MORE) r = STEP_SYNTAX;
            end
        end
        if (r != STEP_MORE)
        begin
            case (r)
                STEP_END_OK: st = dagp_pkg::ST_OK;
                STEP_ROWS:   st = dagp_pkg::ST_ROWS;
                default:     st = dagp_pkg::ST_SYNTAX;
            endcase
            // the status rides on the second field when two are already owed
            if (step_n < 2)
            begin
                push_field(dagp_pkg::KIND_STATUS, '0, '0);
                step_res[step_n - 1].row_index = '0;
            end
            step_res[step_n - 1].status = st;
            step_res[step_n - 1].consumed = ps_chars[dagp_pkg::CONS_W-1:0];
            step_res[step_n - 1].done_res = 1'b1;
            if (is_last) clear_parse();
            else ps_phase = P_DRAIN;
        end
        for (int i = 0; i < step_n; i++)
            expected_fields.push_back(step_res[i]);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] d);
        if (d < 10) return 8'h30 + d;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 8'd10;
    endfunction

    function automatic logic [7:0] b36_char(int d);
        if (d < 10) return 8'(8'h30 + d);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10);
    endfunction

    function automatic void put_str(string s);
        for (int k = 0; k < s.len(); k++)
            txt.push_back(s[k]);
    endfunction

    function automatic void put_hex(logic [31:0] v, int n);
        for (int k = n - 1; k >= 0; k--)
            txt.push_back(hex_char(v[4 * k +: 4]));
    endfunction

    // One row: type, five identifier words, optional edge list
    function automatic void put_row(logic [31:0] typ, int tdig, int nedge);
        int pick;
        put_hex(typ, tdig);
        txt.push_back(dagp_pkg::CH_DASH);
        for (int w = 0; w < dagp_pkg::XID_WORDS; w++)
        begin
            pick = $urandom_range(0, 7);
            put_hex((pick == 0) ? 32'h0 : (pick == 1) ? 32'hffffffff : $urandom,
                    dagp_pkg::XID_DIGITS);
        end
        if (nedge > 0)
        begin
            txt.push_back(dagp_pkg::CH_DASH);
            for (int k = 0; k < nedge; k++)
            begin
                if ($urandom_range(0, 2) == 0) txt.push_back(dagp_pkg::CH_GT);
                if ($urandom_range(0, 5) == 0) txt.push_back(dagp_pkg::CH_STAR);
                else txt.push_back(b36_char($urandom_range(0, 35)));
            end
        end
    endfunction

    // Random address text: mostly well formed, some broken, some noise
    function automatic void build_random_text();
        int          sel;
        int          nrows;
        int          tdig;
        int          pos;
        logic [31:0] typ;
        txt.delete();
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            repeat ($urandom_range(1, 16)) txt.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0) txt.push_back(dagp_pkg::CH_BANG);
        nrows = ($urandom_range(0, 19) == 0)
                ? $urandom_range(dagp_pkg::MAX_ROWS, dagp_pkg::MAX_ROWS + 1)
                : $urandom_range(1, 3);
        for (int r = 0; r < nrows; r++)
        begin
            if (r > 0)
            begin
                txt.push_back(dagp_pkg::CH_COLON);
                if ($urandom_range(0, 1)) txt.push_back(dagp_pkg::CH_NL);
            end
            tdig = $urandom_range(1, TYPE_DIGITS);
            typ = $urandom;
            case ($urandom_range(0, 9))
                0: typ = '0;
                1: typ = '1;
                default: ;
            endcase
            if (tdig < TYPE_DIGITS) typ = typ & ((32'h1 << (4 * tdig)) - 1);
            if ($urandom_range(0, 11) == 0)
            begin
                typ = cfg_reserved_type;
                tdig = TYPE_DIGITS;
            end
            else if (typ == cfg_reserved_type)
            begin
                typ = typ ^ 32'h1;
            end
            put_row(typ, tdig, $urandom_range(0, dagp_pkg::MAX_EDGES));
        end
        // end at the last character, at a lone NUL, or at a NUL with trailing junk
        case ($urandom_range(0, 2))
            1: txt.push_back(dagp_pkg::CH_NUL);
            2:
            begin
                txt.push_back(dagp_pkg::CH_NUL);
                repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        if (sel < 30)
        begin
            pos = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
                0: txt[pos] = 8'($urandom_range(0, 255));
                1: while (txt.size() > pos + 1) void'(txt.pop_back());
                default: txt.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // Hand one item to the block, with an occasional random gap first
    task automatic send_char(input logic [7:0] c, input logic is_last);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        last <= is_last;
        do @(posedge clk); while (in_stall);
        chars_sent++;
        parse_step(c, is_last);
    endtask

    // Drop valid and hold until every owed field has arrived
    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_fields.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic send_text(input int pause_at);
        for (int i = 0; i < txt.size(); i++)
        begin
            if (i == pause_at) wait_drained(0);
            send_char(txt[i], i == txt.size() - 1);
        end
        texts_sent++;
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input bit ignore_chosen, input logic [31:0] reserved_type);
        wait_drained(4);
        cfg_we <= 1'b1;
        cfg_index <= dagp_pkg::REG_IGNORE_CHOSEN;
        cfg_data <= {31'b0, ignore_chosen};
        @(posedge clk);
        cfg_ignore_chosen = ignore_chosen;
        cfg_index <= dagp_pkg::REG_RESERVED_TYPE;
        cfg_data <= reserved_type;
        @(posedge clk);
        cfg_reserved_type = reserved_type;
        cfg_we <= 1'b0;
    endtask

    // Reset register values: type zero is rejected, chosen marks kept
    task automatic test_reset_config();
        txt.delete();
        put_str("0-");
        send_text(-1);
        txt.delete();
        put_str("A");
        put_row(32'h0, 0, 0);
        put_str("-0>z*>Y");
        send_text(-1);
    endtask

    task automatic test_special_cases();
        set_config(1'b0, 32'hffffffff);
        // type equal to the reserved value
        txt.delete();
        put_str("ffffffff-");
        send_text(-1);
        // fifth word completed by the last character
        txt.delete();
        txt.push_back(dagp_pkg::CH_BANG);
        put_row(32'hfffffffe, 8, 0);
        send_text(-1);
        // NUL where a type is expected
        txt.delete();
        txt.push_back(dagp_pkg::CH_BANG);
        txt.push_back(dagp_pkg::CH_NUL);
        put_str("9-");
        send_text(-1);
        // nine type digits, then characters ignored up to the last one
        txt.delete();
        put_str("123456789-x");
        send_text(-1);
        // one separator too many
        txt.delete();
        for (int r = 0; r < dagp_pkg::MAX_ROWS; r++)
        begin
            if (r > 0) txt.push_back(dagp_pkg::CH_COLON);
            if (r % 2) txt.push_back(dagp_pkg::CH_NL);
            put_row(r + 1, 1, r % (dagp_pkg::MAX_EDGES + 1));
        end
        put_str(":zz");
        send_text(-1);
        // repeated chosen mark
        txt.delete();
        put_row(32'h5, 1, 0);
        put_str("->>3");
        send_text(-1);
        // NUL closing an edge list, trailing characters ignored
        txt.delete();
        put_row(32'h7, 1, 0);
        put_str("-*");
        txt.push_back(dagp_pkg::CH_NUL);
        put_str("ab");
        send_text(-1);
        // edge list with no edge before a high-bit character
        txt.delete();
        put_row(32'h2, 1, 0);
        txt.push_back(dagp_pkg::CH_DASH);
        txt.push_back(8'hff);
        txt.push_back(8'h80);
        send_text(-1);
    endtask

    task automatic test_chosen_dropped();
        set_config(1'b1, 32'h00000001);
        txt.delete();
        put_str("01-");
        send_text(-1);
        txt.delete();
        put_row(32'h10, 2, 0);
        put_str("->a>B>*>C:");
        txt.push_back(dagp_pkg::CH_NL);
        put_row(32'h3, 1, 2);
        send_text(-1);
    endtask

    // Pause the sender mid-address until the result side is empty
    task automatic test_pause_for_results();
        set_config(1'b0, 32'h0000abcd);
        repeat (4)
        begin
            build_random_text();
            send_text($urandom_range(0, txt.size() - 1));
        end
    endtask

    task automatic test_random_texts();
        bit          ic_list [5];
        logic [31:0] rt_list [5];
        int          start;
        ic_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        rt_list = '{32'h0, 32'hffffffff, $urandom, $urandom_range(0, 15), 32'h1};
        for (int p = 0; p < 5; p++)
        begin
            set_config(ic_list[p], rt_list[p]);
            start = chars_sent;
            while (chars_sent - start < PHASE_ITEMS)
            begin
                send_gaps = ($urandom_range(0, 7) != 0);
                recv_stalls = ($urandom_range(0, 7) != 0);
                build_random_text();
                send_text(-1);
            end
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate();
        int start;
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        set_config(1'b1, $urandom);
        start = chars_sent;
        while (chars_sent - start < PHASE_ITEMS)
        begin
            build_random_text();
            send_text(-1);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_special_cases();
        test_chosen_dropped();
        test_pause_for_results();
        test_random_texts();
        test_full_rate();
        wait_drained(10);
        $display("covered %0d characters in %0d texts, %0d result fields checked",
                 chars_sent, texts_sent, results_seen);
        $display("chosen marks kept and dropped; reserved type at zero, all ones and random");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: dag_address_text_parser_core.f
rtl/dagp_pkg.sv
rtl/dagp_front.sv
rtl/dagp_back.sv
rtl/dag_address_text_parser_core.sv
verif/dag_address_text_parser_core_tb.sv
